FILE: rtl/corridor_signed_distance_query_macros.svh
// Assertion macros shared by the corridor distance query RTL.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef CORRIDOR_SIGNED_DISTANCE_QUERY_MACROS_SVH
`define CORRIDOR_SIGNED_DISTANCE_QUERY_MACROS_SVH

// same-cycle implication
`define CDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cdq_pkg.sv
// Package for the corridor distance query: item types, codes, datapath widths.
// No dependencies.
package cdq_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_ANSWERED = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_WRITTEN  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [15:0] UNIT_Q14 = 16'd16384;

  // operand / accumulator widths of the multiply-accumulate path
  localparam int unsigned OP_W  = 34;
  localparam int unsigned ACC_W = 68;

  // square root: radicand and root widths
  localparam int unsigned SQ_RAD_W  = 96;
  localparam int unsigned SQ_ROOT_W = 48;

  // divider: dividend, divisor and quotient widths
  localparam int unsigned DV_NUM_W = 82;
  localparam int unsigned DV_DEN_W = 48;
  localparam int unsigned DV_Q_W   = 36;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        win_start;
    logic [31:0]        win_end;
    logic [30:0]        left_half_width;
    logic [30:0]        right_half_width;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        t_rel;
  } cdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] clearance;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
  } cdq_out_t;

  // one table entry
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [31:0]        win_s;
    logic [31:0]        win_e;
    logic [30:0]        lw;
    logic [30:0]        rw;
  } cdq_seg_t;

endpackage

FILE: rtl/cdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cdq_isqrt.sv
// Iterative integer square root, one root bit per cycle.
// Depends on cdq_pkg for widths.
module cdq_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cdq_pkg::SQ_RAD_W-1:0]   rad,
  output logic                           done,
  output logic [cdq_pkg::SQ_ROOT_W-1:0]  root
);

  localparam int unsigned RW    = cdq_pkg::SQ_ROOT_W;
  localparam int unsigned DW    = cdq_pkg::SQ_RAD_W;
  localparam int unsigned CNT_W = $clog2(RW);

  logic [DW-1:0]    rad_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW+3:0]    rem2;
  logic [RW+3:0]    trial;
  logic [RW+3:0]    diff;
  logic             ge;

  assign rem2  = {rem_r, rad_r[DW-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rem2 >= trial;
  assign diff  = rem2 - trial;

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? diff[RW+1:0] : rem2[RW+1:0];
      root_r <= {root_r[RW-2:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(RW - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(RW - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/cdq_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Dividend must be below divisor times 2^DV_Q_W. Depends on cdq_pkg.
module cdq_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cdq_pkg::DV_NUM_W-1:0]  num,
  input  logic [cdq_pkg::DV_DEN_W-1:0]  den,
  output logic                          done,
  output logic [cdq_pkg::DV_Q_W-1:0]    q
);

  localparam int unsigned NW    = cdq_pkg::DV_NUM_W;
  localparam int unsigned DNW   = cdq_pkg::DV_DEN_W;
  localparam int unsigned QW    = cdq_pkg::DV_Q_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic [DNW-1:0]   rem_r;
  logic [DNW-1:0]   den_r;
  logic [QW-1:0]    low_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DNW:0]     r2;
  logic [DNW:0]     diff;
  logic             ge;

  assign r2   = {rem_r, low_r[QW-1]};
  assign ge   = r2 >= {1'b0, den_r};
  assign diff = r2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DNW'(num[NW-1:QW]);
      low_r <= num[QW-1:0];
      den_r <= den;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DNW-1:0] : r2[DNW-1:0];
      low_r <= low_r << 1;
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(QW - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(QW - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

FILE: rtl/corridor_signed_distance_query.sv
// Top level of the corridor signed-distance query: table RAM, scan, sequencer, MAC.
// Depends on cdq_pkg, cdq_ram, cdq_isqrt, cdq_div and the assertion macro header.
`include "corridor_signed_distance_query_macros.svh"

// Corridor signed-distance query. An item is taken when start is high and busy
// is low; its one result appears on out_data for exactly one cycle with
// out_valid high, and the receiver cannot stall it. Clear and append items
// are answered in the cycle after they are taken. A query on a table of n
// segments runs a linear window scan over the segment RAM (one entry per
// cycle), re-reads the chosen entry, then works through a shared 33x17
// multiply-accumulate unit, a bit-serial square root and a bit-serial divider.
// busy stays high for the whole query. The segment table needs no clearing
// pass: only entries below the segment count are read.
module corridor_signed_distance_query #(
  parameter int unsigned MAX_SEGMENTS = cdq_pkg::MAX_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_in_t  in_data,
  output logic              out_valid,
  output cdq_pkg::cdq_out_t out_data
);

  localparam int unsigned AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned OPW   = cdq_pkg::OP_W;
  localparam int unsigned AccW  = cdq_pkg::ACC_W;
  localparam int unsigned SegW  = $bits(cdq_pkg::cdq_seg_t);
  localparam int unsigned FineW = cdq_pkg::SQ_ROOT_W;
  localparam int unsigned QW    = cdq_pkg::DV_Q_W;
  localparam logic signed [37:0] SdMin = -38'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FETCH, S_LOAD, S_MAC, S_SQRT,
    S_DIVX, S_DIVY, S_VDONE, S_DIVC, S_FIN
  } state_t;

  typedef enum logic {PH_AB, PH_VEC} phase_t;
  typedef enum logic [1:0] {K_DEG, K_AB, K_END} kind_t;

  function automatic logic signed [OPW-1:0] sext34(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  function automatic logic [OPW-2:0] mag33(input logic signed [OPW-1:0] x);
    logic signed [OPW-1:0] n;
    n = -x;
    return x[OPW-1] ? n[OPW-2:0] : x[OPW-2:0];
  endfunction

  // quotient clamped to one unit, signed by the vector component
  function automatic logic signed [15:0] unit_comp(input logic [QW-1:0] q, input logic neg);
    logic [15:0] m;
    m = (q > QW'(cdq_pkg::UNIT_Q14)) ? cdq_pkg::UNIT_Q14 : q[15:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // control
  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  kind_t   kind_r, kind_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic          rv_r, rv_nxt;
  logic [2:0]    term_r, term_nxt;
  logic          half_r, half_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  cdq_pkg::cdq_in_t  in_r, in_nxt;
  cdq_pkg::cdq_out_t out_r, out_nxt;
  logic [31:0]       first_ws_r, first_ws_nxt;
  logic [AW-1:0]     sel_r, sel_nxt;
  logic signed [OPW-1:0] abx_r, aby_r, wx_r, wy_r, dex_r, dey_r, vx_r, vy_r;
  logic signed [OPW-1:0] abx_nxt, aby_nxt, wx_nxt, wy_nxt, dex_nxt, dey_nxt, vx_nxt, vy_nxt;
  logic [30:0]           lw_r, rw_r, width_r, lw_nxt, rw_nxt, width_nxt;
  logic signed [AccW-1:0] acc_r, lensq_r, cr_r, proj_r;
  logic signed [AccW-1:0] acc_nxt, lensq_nxt, cr_nxt, proj_nxt;
  logic [FineW-1:0]      fine_r, fine_nxt;
  logic signed [15:0]    ux_r, uy_r, gx_r, gy_r, ux_nxt, uy_nxt, gx_nxt, gy_nxt;
  logic [QW-1:0]         dist_r, dist_nxt;

  // RAM
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  cdq_pkg::cdq_seg_t    seg_w, rd;
  logic [SegW-1:0]      ram_rdata;

  // units
  logic                             sqrt_start, sqrt_done;
  logic [cdq_pkg::SQ_RAD_W-1:0]     sqrt_rad;
  logic [FineW-1:0]                 sqrt_root;
  logic                             div_start, div_done;
  logic [cdq_pkg::DV_NUM_W-1:0]     div_num;
  logic [cdq_pkg::DV_DEN_W-1:0]     div_den;
  logic [QW-1:0]                    div_q;

  // misc combinational
  logic                  accept;
  logic [CW-1:0]         last_idx;
  logic [31:0]           ws0;
  logic signed [OPW-1:0] mac_a, mac_b;
  logic                  mac_neg;
  logic [OPW-2:0]        mac_am, mac_bm;
  logic [16:0]           mac_chunk;
  logic [49:0]           mac_prod;
  logic [AccW-1:0]       mac_ext;
  logic signed [AccW-1:0] mac_contrib, mac_base, mac_sum;
  logic                  cr_left, proj_le0, proj_past;
  logic signed [AccW-1:0] cr_mag;
  logic signed [OPW-1:0] ld_wx, ld_wy;
  logic signed [37:0]    sd_diff;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign last_idx = count_r - CW'(1);
  assign rd       = cdq_pkg::cdq_seg_t'(ram_rdata);

  cdq_ram #(
    .WIDTH  (SegW),
    .DEPTH  (MAX_SEGMENTS),
    .ADDR_W (AW)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (seg_w),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cdq_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  cdq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // MAC program: AB phase gives lensq, cross and projection; VEC phase |v|^2
  always_comb begin
    mac_a   = vx_r;
    mac_b   = vx_r;
    mac_neg = 1'b0;
    if (phase_r == PH_AB) begin
      case (term_r)
        3'd0: begin mac_a = abx_r; mac_b = abx_r; end
        3'd1: begin mac_a = aby_r; mac_b = aby_r; end
        3'd2: begin mac_a = abx_r; mac_b = wy_r; end
        3'd3: begin mac_a = aby_r; mac_b = wx_r; mac_neg = 1'b1; end
        3'd4: begin mac_a = wx_r;  mac_b = abx_r; end
        3'd5: begin mac_a = wy_r;  mac_b = aby_r; end
        default: begin mac_a = abx_r; mac_b = abx_r; end
      endcase
    end else if (term_r[0]) begin
      mac_a = vy_r;
      mac_b = vy_r;
    end
  end

  // one 33x17 partial product per cycle, low half then high half
  assign mac_am      = mag33(mac_a);
  assign mac_bm      = mag33(mac_b);
  assign mac_chunk   = half_r ? {1'b0, mac_bm[OPW-2:17]} : mac_bm[16:0];
  assign mac_prod    = mac_am * mac_chunk;
  assign mac_ext     = half_r ? (AccW'(mac_prod) << 17) : AccW'(mac_prod);
  assign mac_contrib = (mac_a[OPW-1] ^ mac_b[OPW-1] ^ mac_neg) ? -$signed(mac_ext)
                                                               : $signed(mac_ext);
  assign mac_base    = (!term_r[0] && !half_r) ? '0 : acc_r;
  assign mac_sum     = mac_base + mac_contrib;

  assign cr_left   = !cr_r[AccW-1];
  assign cr_mag    = cr_r[AccW-1] ? -cr_r : cr_r;
  assign proj_le0  = proj_r[AccW-1] || (proj_r == '0);
  assign proj_past = lensq_r <= proj_r;
  assign ws0       = (chk_idx_r == '0) ? rd.win_s : first_ws_r;
  assign ld_wx     = sext34(in_r.pos_x) - sext34(rd.sx);
  assign ld_wy     = sext34(in_r.pos_y) - sext34(rd.sy);
  assign sd_diff   = $signed({7'b0, width_r}) - $signed({2'b0, dist_r});

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    rv_nxt        = 1'b0;
    term_nxt      = term_r;
    half_nxt      = half_r;
    out_valid_nxt = 1'b0;
    in_nxt        = in_r;
    out_nxt       = out_r;
    first_ws_nxt  = first_ws_r;
    sel_nxt       = sel_r;
    abx_nxt = abx_r; aby_nxt = aby_r; wx_nxt = wx_r; wy_nxt = wy_r;
    dex_nxt = dex_r; dey_nxt = dey_r; vx_nxt = vx_r; vy_nxt = vy_r;
    lw_nxt = lw_r; rw_nxt = rw_r; width_nxt = width_r;
    acc_nxt = acc_r; lensq_nxt = lensq_r; cr_nxt = cr_r; proj_nxt = proj_r;
    fine_nxt = fine_r;
    ux_nxt = ux_r; uy_nxt = uy_r; gx_nxt = gx_r; gy_nxt = gy_r;
    dist_nxt = dist_r;

    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    seg_w.sx    = in_data.start_x;
    seg_w.sy    = in_data.start_y;
    seg_w.ex    = in_data.end_x;
    seg_w.ey    = in_data.end_y;
    seg_w.win_s = in_data.win_start;
    seg_w.win_e = in_data.win_end;
    seg_w.lw    = in_data.left_half_width;
    seg_w.rw    = in_data.right_half_width;
    ram_re    = 1'b0;
    ram_raddr = sel_r;

    sqrt_start = 1'b0;
    sqrt_rad   = cdq_pkg::SQ_RAD_W'(mac_sum[64:0]) << 28;
    div_start  = 1'b0;
    div_num    = cdq_pkg::DV_NUM_W'(mag33(vx_r)) << 28;
    div_den    = fine_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_nxt            = in_data;
          out_nxt.status    = cdq_pkg::ST_WRITTEN;
          out_nxt.clearance = '0;
          out_nxt.grad_x    = '0;
          out_nxt.grad_y    = '0;
          case (in_data.req_type)
            cdq_pkg::REQ_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            cdq_pkg::REQ_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r < CW'(MAX_SEGMENTS)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                out_nxt.status = cdq_pkg::ST_FULL;
              end
            end
            cdq_pkg::REQ_QUERY: begin
              if (count_r == '0) begin
                out_valid_nxt     = 1'b1;
                out_nxt.status    = cdq_pkg::ST_EMPTY;
                out_nxt.clearance = 32'sh80000000;
              end else begin
                scan_idx_nxt = '0;
                state_nxt    = S_SCAN;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end

      // reads are pipelined: address for scan_idx, check of chk_idx data
      S_SCAN: begin
        ram_raddr   = scan_idx_r[AW-1:0];
        chk_idx_nxt = scan_idx_r;
        if (scan_idx_r < count_r) begin
          ram_re       = 1'b1;
          rv_nxt       = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
        if (rv_r) begin
          if (chk_idx_r == '0) begin
            first_ws_nxt = rd.win_s;
          end
          if ((in_r.t_rel >= rd.win_s) && (in_r.t_rel <= rd.win_e)) begin
            sel_nxt   = chk_idx_r[AW-1:0];
            state_nxt = S_FETCH;
          end else if (chk_idx_r == last_idx) begin
            sel_nxt   = (in_r.t_rel < ws0) ? '0 : last_idx[AW-1:0];
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        abx_nxt  = sext34(rd.ex) - sext34(rd.sx);
        aby_nxt  = sext34(rd.ey) - sext34(rd.sy);
        wx_nxt   = ld_wx;
        wy_nxt   = ld_wy;
        dex_nxt  = sext34(in_r.pos_x) - sext34(rd.ex);
        dey_nxt  = sext34(in_r.pos_y) - sext34(rd.ey);
        lw_nxt   = rd.lw;
        rw_nxt   = rd.rw;
        term_nxt = '0;
        half_nxt = 1'b0;
        state_nxt = S_MAC;
        if ((rd.ex == rd.sx) && (rd.ey == rd.sy)) begin
          kind_nxt  = K_DEG;
          phase_nxt = PH_VEC;
          vx_nxt    = ld_wx;
          vy_nxt    = ld_wy;
        end else begin
          kind_nxt  = K_AB;
          phase_nxt = PH_AB;
        end
      end

      S_MAC: begin
        acc_nxt  = mac_sum;
        half_nxt = !half_r;
        if (half_r) begin
          term_nxt = term_r + 3'd1;
          if (phase_r == PH_AB) begin
            case (term_r)
              3'd1: lensq_nxt = mac_sum;
              3'd3: cr_nxt    = mac_sum;
              3'd5: begin
                proj_nxt  = mac_sum;
                vx_nxt    = abx_r;
                vy_nxt    = aby_r;
                phase_nxt = PH_VEC;
                term_nxt  = '0;
              end
              default: ;
            endcase
          end else if (term_r[0]) begin
            sqrt_start = 1'b1;
            state_nxt  = S_SQRT;
          end
        end
      end

      S_SQRT: begin
        if (sqrt_done) begin
          fine_nxt = sqrt_root;
          if (sqrt_root == '0) begin
            ux_nxt    = '0;
            uy_nxt    = '0;
            state_nxt = S_VDONE;
          end else begin
            div_start = 1'b1;
            div_den   = sqrt_root;
            state_nxt = S_DIVX;
          end
        end
      end

      S_DIVX: begin
        if (div_done) begin
          ux_nxt    = unit_comp(div_q, vx_r[OPW-1]);
          div_start = 1'b1;
          div_num   = cdq_pkg::DV_NUM_W'(mag33(vy_r)) << 28;
          state_nxt = S_DIVY;
        end
      end

      S_DIVY: begin
        if (div_done) begin
          uy_nxt    = unit_comp(div_q, vy_r[OPW-1]);
          state_nxt = S_VDONE;
        end
      end

      S_VDONE: begin
        case (kind_r)
          K_DEG: begin
            width_nxt = (lw_r < rw_r) ? lw_r : rw_r;
            dist_nxt  = QW'(fine_r[FineW-1:14]);
            if (fine_r == '0) begin
              gx_nxt = '0;
              gy_nxt = $signed(cdq_pkg::UNIT_Q14);
            end else begin
              gx_nxt = -ux_r;
              gy_nxt = -uy_r;
            end
            state_nxt = S_FIN;
          end
          K_AB: begin
            // normal is the tangent turned toward the segment
            width_nxt = cr_left ? lw_r : rw_r;
            gx_nxt    = cr_left ? uy_r : -uy_r;
            gy_nxt    = cr_left ? -ux_r : ux_r;
            if (proj_le0 || proj_past) begin
              vx_nxt    = proj_le0 ? wx_r : dex_r;
              vy_nxt    = proj_le0 ? wy_r : dey_r;
              kind_nxt  = K_END;
              phase_nxt = PH_VEC;
              term_nxt  = '0;
              half_nxt  = 1'b0;
              state_nxt = S_MAC;
            end else begin
              div_start = 1'b1;
              div_num   = cdq_pkg::DV_NUM_W'(cr_mag) << 14;
              state_nxt = S_DIVC;
            end
          end
          K_END: begin
            dist_nxt = QW'(fine_r[FineW-1:14]);
            if (fine_r != '0) begin
              gx_nxt = -ux_r;
              gy_nxt = -uy_r;
            end
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end

      S_DIVC: begin
        if (div_done) begin
          dist_nxt  = div_q;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        out_valid_nxt     = 1'b1;
        out_nxt.status    = cdq_pkg::ST_ANSWERED;
        out_nxt.clearance = (sd_diff < SdMin) ? 32'sh80000000 : sd_diff[31:0];
        out_nxt.grad_x    = gx_r;
        out_nxt.grad_y    = gy_r;
        state_nxt         = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    kind_r     <= kind_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    term_r     <= term_nxt;
    half_r     <= half_nxt;
    in_r       <= in_nxt;
    out_r      <= out_nxt;
    first_ws_r <= first_ws_nxt;
    sel_r      <= sel_nxt;
    abx_r <= abx_nxt; aby_r <= aby_nxt; wx_r <= wx_nxt; wy_r <= wy_nxt;
    dex_r <= dex_nxt; dey_r <= dey_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt;
    lw_r <= lw_nxt; rw_r <= rw_nxt; width_r <= width_nxt;
    acc_r <= acc_nxt; lensq_r <= lensq_nxt; cr_r <= cr_nxt; proj_r <= proj_nxt;
    fine_r <= fine_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt; gx_r <= gx_nxt; gy_r <= gy_nxt;
    dist_r <= dist_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CDQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_SEGMENTS), "segment count above capacity")
  `CDQ_ASSERT_NXT(a_item_taken, start && !busy, out_valid || busy, "accepted item neither answered nor in work")
  `CDQ_ASSERT_IMP(a_scan_in_table, (state_r == S_SCAN) && rv_r, chk_idx_r < count_r, "scan checks an entry beyond the table")
  `CDQ_ASSERT_IMP(a_grad_unit, out_valid && (out_data.status == cdq_pkg::ST_ANSWERED), (out_data.grad_x <= 16'sd16384) && (out_data.grad_x >= -16'sd16384) && (out_data.grad_y <= 16'sd16384) && (out_data.grad_y >= -16'sd16384), "gradient beyond one unit")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for corridor_signed_distance_query: random and directed items.
// Depends on cdq_pkg and the corridor_signed_distance_query RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;  // unused request code
  localparam int unsigned N_RAND = 1950;

  logic              clk;
  logic              rst_n;
  logic              start = 1'b0;
  logic              busy;
  cdq_pkg::cdq_in_t  in_data = '0;
  logic              out_valid;
  cdq_pkg::cdq_out_t out_data;

  corridor_signed_distance_query u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // stimulus and expectations
  cdq_pkg::cdq_in_t  pending_items[$];
  cdq_pkg::cdq_out_t expected_answers[$];
  int unsigned total_items = 0;
  int unsigned items_taken = 0;
  int unsigned taken_seen = 0;
  int unsigned mismatches = 0;

  // predictor copy of the segment table
  cdq_pkg::cdq_seg_t seg_tab[cdq_pkg::MAX_SEGMENTS];
  int unsigned       seg_n = 0;

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic logic [63:0] isqrt128(input logic [127:0] s);
    logic [63:0] r, c;
    int b;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // length in Q16.30 and unit vector in Q2.14; zero vector gives zero
  function automatic logic [63:0] unit_vec(input logic signed [127:0] vx,
                                           input logic signed [127:0] vy,
                                           output logic signed [127:0] gx,
                                           output logic signed [127:0] gy);
    logic [127:0] mx, my, s, qx, qy;
    logic [63:0]  fine;
    mx = (vx < 0) ? -vx : vx;
    my = (vy < 0) ? -vy : vy;
    s = mx * mx + my * my;
    fine = isqrt128(s << 28);
    gx = 0;
    gy = 0;
    if (fine != 0) begin
      qx = (mx << 28) / {64'd0, fine};
      qy = (my << 28) / {64'd0, fine};
      if (qx > 128'(cdq_pkg::UNIT_Q14)) qx = 128'(cdq_pkg::UNIT_Q14);
      if (qy > 128'(cdq_pkg::UNIT_Q14)) qy = 128'(cdq_pkg::UNIT_Q14);
      gx = (vx < 0) ? -$signed(qx) : $signed(qx);
      gy = (vy < 0) ? -$signed(qy) : $signed(qy);
    end
    return fine;
  endfunction

  // applies one item to the table copy and returns its answer
  function automatic cdq_pkg::cdq_out_t distance_answer(input cdq_pkg::cdq_in_t it);
    cdq_pkg::cdq_out_t r;
    cdq_pkg::cdq_seg_t sg;
    logic signed [127:0] px, py, abx, aby, wx, wy, dx, dy, cr, proj, lensq;
    logic signed [127:0] gx, gy, tx, ty, ux, uy, width, sd;
    logic [127:0] span, cm;
    logic [63:0]  fine;
    int unsigned sel, i;
    bit found, left, at_start;
    r = '0;
    r.status = cdq_pkg::ST_WRITTEN;
    gx = 0;
    gy = 0;
    case (it.req_type)
      cdq_pkg::REQ_CLEAR: seg_n = 0;
      cdq_pkg::REQ_APPEND: begin
        if (seg_n >= cdq_pkg::MAX_SEGMENTS) begin
          r.status = cdq_pkg::ST_FULL;
        end else begin
          seg_tab[seg_n] = '{it.start_x, it.start_y, it.end_x, it.end_y,
                             it.win_start, it.win_end,
                             it.left_half_width, it.right_half_width};
          seg_n++;
        end
      end
      cdq_pkg::REQ_QUERY: begin
        if (seg_n == 0) begin
          r.status = cdq_pkg::ST_EMPTY;
          r.clearance = 32'sh8000_0000;
        end else begin
          found = 0;
          sel = 0;
          for (i = 0; i < seg_n && !found; i++)
            if (it.t_rel >= seg_tab[i].win_s && it.t_rel <= seg_tab[i].win_e) begin
              sel = i;
              found = 1;
            end
          // fallback: first segment if early, else the last one
          if (!found) sel = (it.t_rel < seg_tab[0].win_s) ? 0 : seg_n - 1;
          sg = seg_tab[sel];
          px = 128'(it.pos_x);
          py = 128'(it.pos_y);
          abx = 128'(sg.ex) - 128'(sg.sx);
          aby = 128'(sg.ey) - 128'(sg.sy);
          wx = px - 128'(sg.sx);
          wy = py - 128'(sg.sy);
          if (abx == 0 && aby == 0) begin
            // degenerate: narrower side, gradient toward the start
            width = 128'((sg.lw < sg.rw) ? sg.lw : sg.rw);
            fine = unit_vec(wx, wy, gx, gy);
            span = 128'(fine >> 14);
            if (fine == 0) begin
              gx = 0;
              gy = 128'(cdq_pkg::UNIT_Q14);
            end else begin
              gx = -gx;
              gy = -gy;
            end
          end else begin
            fine = unit_vec(abx, aby, tx, ty);
            cr = abx * wy - aby * wx;
            proj = wx * abx + wy * aby;
            lensq = abx * abx + aby * aby;
            left = (cr >= 0);
            width = left ? 128'(sg.lw) : 128'(sg.rw);
            if (left) begin
              gx = ty;
              gy = -tx;
            end else begin
              gx = -ty;
              gy = tx;
            end
            if (proj <= 0 || lensq <= proj) begin
              at_start = (proj <= 0);
              dx = at_start ? wx : px - 128'(sg.ex);
              dy = at_start ? wy : py - 128'(sg.ey);
              fine = unit_vec(dx, dy, ux, uy);
              span = 128'(fine >> 14);
              if (fine != 0) begin
                gx = -ux;
                gy = -uy;
              end
            end else begin
              cm = (cr < 0) ? -cr : cr;
              span = (cm << 14) / {64'd0, fine};
            end
          end
          if (span > (128'd1 << 40)) span = 128'd1 << 40;
          sd = width - $signed(span);
          if (sd < -128'sd2147483648) sd = -128'sd2147483648;
          if (sd > 128'sd2147483647) sd = 128'sd2147483647;
          r.status = cdq_pkg::ST_ANSWERED;
          r.clearance = sd[31:0];
          r.grad_x = gx[15:0];
          r.grad_y = gy[15:0];
        end
      end
      default: ;  // spare code: no change
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;  // +/-16 m
    endcase
  endfunction

  function automatic logic [30:0] rnd_width();
    case ($urandom_range(3))
      0:       return 31'($urandom);
      1:       return $urandom_range(1) ? 31'h7fff_ffff : 31'd0;
      default: return 31'($urandom_range(32'h0008_0000));
    endcase
  endfunction

  // every field random; req_type set by caller
  function automatic cdq_pkg::cdq_in_t rnd_item(input logic [1:0] req);
    cdq_pkg::cdq_in_t it;
    it = '{req, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           31'($urandom), 31'($urandom), $urandom, $urandom, $urandom};
    return it;
  endfunction

  cdq_pkg::cdq_in_t last_seg;  // generator's view of the latest segment

  function automatic cdq_pkg::cdq_in_t rnd_append();
    cdq_pkg::cdq_in_t it;
    it = rnd_item(cdq_pkg::REQ_APPEND);
    it.start_x = rnd_coord();
    it.start_y = rnd_coord();
    if ($urandom_range(7) == 0) begin
      it.end_x = it.start_x;
      it.end_y = it.start_y;
    end else begin
      it.end_x = rnd_coord();
      it.end_y = rnd_coord();
    end
    if ($urandom_range(5) != 0) begin
      it.win_start = $urandom_range(2000);
      it.win_end = it.win_start + $urandom_range(400) - 40;  // some inverted
    end
    it.left_half_width = rnd_width();
    it.right_half_width = rnd_width();
    last_seg = it;
    return it;
  endfunction

  function automatic cdq_pkg::cdq_in_t rnd_query();
    cdq_pkg::cdq_in_t it;
    it = rnd_item(cdq_pkg::REQ_QUERY);
    case ($urandom_range(6))
      0: begin it.pos_x = last_seg.start_x; it.pos_y = last_seg.start_y; end
      1: begin it.pos_x = last_seg.end_x;   it.pos_y = last_seg.end_y;   end
      2: ;  // full random point
      3: begin
        // near the midpoint, exercises the interior branch
        it.pos_x = (last_seg.start_x >>> 1) + (last_seg.end_x >>> 1)
                   + $urandom_range(2000) - 1000;
        it.pos_y = (last_seg.start_y >>> 1) + (last_seg.end_y >>> 1)
                   + $urandom_range(2000) - 1000;
      end
      default: begin it.pos_x = rnd_coord(); it.pos_y = rnd_coord(); end
    endcase
    if ($urandom_range(4) != 0) it.t_rel = $urandom_range(2500);
    return it;
  endfunction

  // appends one item to the driver queue
  task automatic queue_item(input cdq_pkg::cdq_in_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // ---------------------------------------------------------------
  // Clock, reset, driver, monitor
  // ---------------------------------------------------------------
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1;
  end

  // idle percentage by quarter of the run
  function automatic int unsigned idle_pct();
    case (items_taken * 4 / (total_items + 1))
      1:       return 79;
      3:       return 17;
      default: return 0;
    endcase
  endfunction

  // a rise of items_taken since the last falling edge means the item went in
  always @(negedge clk) begin
    if (rst_n && (!start || items_taken != taken_seen)) begin
      if (pending_items.size() == 0 || $urandom_range(99) < idle_pct()) begin
        start <= 0;
      end else begin
        start <= 1;
        in_data <= pending_items.pop_front();
      end
    end
    taken_seen = items_taken;
  end

  always @(posedge clk) begin
    cdq_pkg::cdq_out_t want;
    cdq_pkg::cdq_out_t pred;
    if (rst_n) begin
      // results come no earlier than the cycle after their item, so check first
      if (out_valid) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_answers.pop_front();
          if (out_data.status !== want.status
              || out_data.clearance !== want.clearance
              || out_data.grad_x !== want.grad_x
              || out_data.grad_y !== want.grad_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected st=%0d sd=%0d gx=%0d gy=%0d, got st=%0d sd=%0d gx=%0d gy=%0d",
                       want.status, want.clearance, want.grad_x, want.grad_y,
                       out_data.status, out_data.clearance,
                       out_data.grad_x, out_data.grad_y);
          end
        end
      end
      if (start && !busy) begin
        pred = distance_answer(in_data);
        expected_answers.insert(expected_answers.size(), pred);
        items_taken++;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    cdq_pkg::cdq_in_t it;
    int unsigned k, n;

    // directed: empty table, degenerate segment, two full segments
    queue_item(rnd_item(cdq_pkg::REQ_QUERY));
    it = rnd_item(cdq_pkg::REQ_APPEND);
    it.start_x = 32'sh0001_0000; it.start_y = -32'sh0002_0000;
    it.end_x = it.start_x;       it.end_y = it.start_y;
    it.win_start = 10; it.win_end = 20;
    it.left_half_width = 31'h0003_0000; it.right_half_width = 31'h0001_0000;
    queue_item(it);
    last_seg = it;
    it = rnd_item(cdq_pkg::REQ_QUERY);  // point on a degenerate start
    it.pos_x = last_seg.start_x; it.pos_y = last_seg.start_y;
    queue_item(it);
    it.pos_x = 32'sh0005_0000;   // off it
    queue_item(it);
    it = rnd_item(REQ_SPARE);
    queue_item(it);
    queue_item(rnd_item(cdq_pkg::REQ_CLEAR));

    it = rnd_item(cdq_pkg::REQ_APPEND);
    it.start_x = 0; it.start_y = 0; it.end_x = 32'sh000a_0000; it.end_y = 0;
    it.win_start = 100; it.win_end = 50;  // inverted window
    it.left_half_width = 31'h7fff_ffff; it.right_half_width = '0;
    queue_item(it);
    it.start_x = 32'sh8000_0000; it.start_y = 32'sh8000_0000;
    it.end_x = 32'sh7fff_ffff;   it.end_y = 32'sh7fff_ffff;
    it.win_start = 200; it.win_end = 32'hffff_ffff;
    it.left_half_width = 31'h0002_0000; it.right_half_width = 31'h7fff_ffff;
    queue_item(it);
    last_seg = it;
    for (k = 0; k < 8; k++) begin
      it = rnd_item(cdq_pkg::REQ_QUERY);
      case (k)
        0: begin it.pos_x = 32'sh0005_0000; it.pos_y = 32'sh0001_0000; it.t_rel = 0; end
        1: begin it.pos_x = 32'sh0005_0000; it.pos_y = -32'sh0001_0000; it.t_rel = 75; end
        2: begin it.pos_x = -32'sh0003_0000; it.pos_y = 0; it.t_rel = 10; end
        3: begin it.pos_x = 32'sh000f_0000; it.pos_y = 32'sh0002_0000; it.t_rel = 60; end
        4: begin it.pos_x = 32'sh000a_0000; it.pos_y = 0; it.t_rel = 0; end
        5: begin it.pos_x = 32'sh8000_0000; it.pos_y = 32'sh7fff_ffff; it.t_rel = 300; end
        6: begin it.pos_x = 32'sh7fff_ffff; it.pos_y = 32'sh8000_0000; it.t_rel = 32'hffff_ffff; end
        default: begin it.pos_x = 32'sh7fff_ffff; it.pos_y = 32'sh7fff_ffff; it.t_rel = 250; end
      endcase
      queue_item(it);
    end

    // random: well-formed sessions, with a couple of table fills
    n = 0;
    while (n < N_RAND) begin
      if (n == 400 || n == 1400) begin
        queue_item(rnd_item(cdq_pkg::REQ_CLEAR));
        for (k = 0; k < cdq_pkg::MAX_SEGMENTS + 3; k++) queue_item(rnd_append());
        for (k = 0; k < 6; k++) queue_item(rnd_query());
        n += cdq_pkg::MAX_SEGMENTS + 10;
      end else begin
        case ($urandom_range(15))
          0:       queue_item(rnd_item(cdq_pkg::REQ_CLEAR));
          1:       queue_item(rnd_item(REQ_SPARE));
          2:       queue_item(rnd_item(2'($urandom_range(3))));  // noise
          3, 4:    queue_item(rnd_append());
          default: queue_item(rnd_query());
        endcase
        n++;
      end
    end
    total_items = pending_items.size();

    // drain: all items taken, all results seen, then a latency margin
    while (items_taken < total_items || expected_answers.size() != 0)
      @(posedge clk);
    repeat (cdq_pkg::MAX_SEGMENTS + 400) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_isqrt.sv
rtl/cdq_div.sv
rtl/corridor_signed_distance_query.sv
dv/tb_top.sv
